// File: rtl/ifp_pkg.sv
// ============================================================================
// ifp_pkg
// Shared constants, the frame type and the angle scaling function for the IMU angle
// frame parser.
// ============================================================================
`default_nettype none

package ifp_pkg;

    localparam int unsigned FRAME_LEN  = 11;
    localparam int unsigned CNT_W      = 4;
    localparam int unsigned NUM_DATA   = 6;
    localparam int unsigned DATA_IDX_W = 3;
    localparam int unsigned ANGLE_W    = 24;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ANGLE = 8'h53;

    // Byte positions inside a frame.
    localparam logic [CNT_W-1:0] POS_TYPE       = 4'd1;
    localparam logic [CNT_W-1:0] POS_DATA_FIRST = 4'd2;
    localparam logic [CNT_W-1:0] POS_DATA_LAST  = 4'd7;
    localparam logic [CNT_W-1:0] POS_CHECKSUM   = 4'd10;

    // Result of the byte currently being processed by the collector.
    typedef struct packed {
        logic               hit;
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } ifp_frame_t;

    // Raw times 180 as shifts and adds: 180 = 128 + 32 + 16 + 4.
    function automatic logic signed [ANGLE_W-1:0] scale_angle(
        input logic signed [15:0] raw
    );
        logic signed [ANGLE_W-1:0] ext;
        begin
            ext = ANGLE_W'(raw);
            scale_angle = (ext <<< 7) + (ext <<< 5) + (ext <<< 4) + (ext <<< 2);
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/imu_angle_frame_parser_unit.sv
// ============================================================================
// imu_angle_frame_parser_unit
// Parses 11-byte angle frames from a serial byte stream and emits roll, pitch
// and yaw in degrees scaled by 2^15.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ---------------------------------
// input     in         in_valid / in_stall    rx_byte (8 bit unsigned)
// output    out        out_valid / out_stall  angle_x/y/z (24 bit signed each)
//
// One byte is taken per cycle when the output side keeps up. A byte is first
// captured in an input register, where the frame collector works on it; a
// good frame's angles are loaded into the result register when the checksum
// byte moves on from the input register, and out_valid rises with that load.
// Reset clears the frame state and both valid flags; stored frame bytes are
// not cleared, since each is written within a frame before it is read.
// The input side stalls only when the byte waiting in the input register
// would complete a good frame while the result register still holds a
// result that the receiver is stalling.
// ============================================================================
`default_nettype none

module imu_angle_frame_parser_unit
    import ifp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [7:0]                rx_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [ANGLE_W-1:0]      angle_x,
    output logic signed [ANGLE_W-1:0]      angle_y,
    output logic signed [ANGLE_W-1:0]      angle_z
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;
    logic       step;
    ifp_frame_t frame;

    // The pending byte moves on unless it would produce a result that has
    // nowhere to go.
    assign advance  = !frame.hit || !out_valid || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign step     = in_valid_reg && advance;

    assign in_valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    ifp_collector u_collector (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .byte_data (in_byte_reg),
        .frame     (frame)
    );

    ifp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && frame.hit),
        .frame     (frame),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .angle_x   (angle_x),
        .angle_y   (angle_y),
        .angle_z   (angle_z)
    );

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && frame.hit))
        else $error("input stalled without a blocked result");

    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
        (step && frame.hit) |=> out_valid)
        else $error("good frame produced no result");

endmodule

`default_nettype wire

// File: rtl/ifp_collector.sv
// ============================================================================
// ifp_collector
// Frame state, running checksum and storage of the type and angle bytes.
// ============================================================================
`default_nettype none

module ifp_collector
    import ifp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] byte_data,
    output ifp_frame_t      frame
);

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       sum_reg;
    logic [7:0]       sum_next;
    logic [7:0]       type_reg;
    logic [7:0]       data_reg [NUM_DATA];
    logic             is_last;
    logic             is_data;
    logic [CNT_W-1:0] data_off;

    assign is_last  = in_frame_reg && (count_reg == POS_CHECKSUM);
    assign is_data  = in_frame_reg && (count_reg >= POS_DATA_FIRST)
                      && (count_reg <= POS_DATA_LAST);
    assign data_off = count_reg - POS_DATA_FIRST;

    // The angle bytes are all stored before the checksum byte arrives.
    assign frame.hit   = is_last && (type_reg == TYPE_ANGLE) && (sum_reg == byte_data);
    assign frame.raw_x = {data_reg[1], data_reg[0]};
    assign frame.raw_y = {data_reg[3], data_reg[2]};
    assign frame.raw_z = {data_reg[5], data_reg[4]};

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (byte_data == HDR_BYTE)
                begin
                    in_frame_next = 1'b1;
                    count_next    = 4'd1;
                    sum_next      = byte_data;
                end
            end
            else if (is_last)
            begin
                in_frame_next = 1'b0;
                count_next    = '0;
            end
            else
            begin
                count_next = count_reg + 4'd1;
                sum_next   = sum_reg + byte_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_frame_reg && (count_reg == POS_TYPE))
        begin
            type_reg <= byte_data;
        end
        if (step && is_data)
        begin
            data_reg[data_off[DATA_IDX_W-1:0]] <= byte_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_CHECKSUM)
        else $error("byte count beyond checksum position");

    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (count_reg == '0))
        else $error("byte count nonzero while idle");

    a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (count_reg != '0))
        else $error("byte count zero inside a frame");

endmodule

`default_nettype wire

// File: rtl/ifp_out_stage.sv
// ============================================================================
// ifp_out_stage
// Converts raw angles to scaled degrees and holds the result register.
// ============================================================================
`default_nettype none

module ifp_out_stage
    import ifp_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      load,
    input  wire ifp_frame_t                frame,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic signed [ANGLE_W-1:0]      angle_x,
    output logic signed [ANGLE_W-1:0]      angle_y,
    output logic signed [ANGLE_W-1:0]      angle_z
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [ANGLE_W-1:0] x_reg;
    logic signed [ANGLE_W-1:0] y_reg;
    logic signed [ANGLE_W-1:0] z_reg;

    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= scale_angle(frame.raw_x);
            y_reg <= scale_angle(frame.raw_y);
            z_reg <= scale_angle(frame.raw_z);
        end
    end

    assign out_valid = valid_reg;
    assign angle_x   = x_reg;
    assign angle_y   = y_reg;
    assign angle_z   = z_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || !out_stall))
        else $error("result register loaded while holding an untaken result");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    a_load_hit: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> frame.hit)
        else $error("result loaded without a valid frame");

endmodule

`default_nettype wire
